// File: design/assert_macros.svh
// Assertion macros shared by the line rasterizer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check that a property holds on every clock edge out of reset.
`define CLR_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("line rasterizer check failed");

// Check that a condition in one cycle implies another in the next cycle.
`define CLR_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("line rasterizer check failed");

`else

`define CLR_ASSERT(lbl, prop)
`define CLR_ASSERT_NEXT(lbl, pre, post)

`endif

`endif

// File: design/clr_pkg.sv
// Types and constants shared by the line rasterizer modules.
`timescale 1ns / 1ps

package clr_pkg;

  localparam int CLR_COORD_BITS    = 12;
  localparam int CLR_FB_BITS       = 12;
  localparam int CLR_PIX_BITS      = 11;
  localparam int CLR_COLOR_BITS    = 32;
  localparam int CLR_CFG_ADDR_BITS = 1;

  localparam logic [CLR_FB_BITS-1:0] CLR_FB_WIDTH_RST  = 12'd640;
  localparam logic [CLR_FB_BITS-1:0] CLR_FB_HEIGHT_RST = 12'd480;

  // Configuration register indexes.
  typedef enum logic [CLR_CFG_ADDR_BITS-1:0] {
    CFG_FB_WIDTH  = 1'b0,
    CFG_FB_HEIGHT = 1'b1
  } cfg_reg_t;

  // Request codes of an input beat.
  typedef enum logic {
    REQ_START = 1'b0,
    REQ_STEP  = 1'b1
  } req_type_t;

  // Line classification held while a line is walked.
  typedef enum logic [2:0] {
    KIND_POINT  = 3'd0,
    KIND_VERT   = 3'd1,
    KIND_HORIZ  = 3'd2,
    KIND_XMAJOR = 3'd3,
    KIND_YMAJOR = 3'd4
  } kind_t;

  // One clipped pixel of a result.
  typedef struct packed {
    logic [CLR_PIX_BITS-1:0] x;
    logic [CLR_PIX_BITS-1:0] y;
    logic                    valid;
  } pixel_t;

  // Everything one step result carries.
  typedef struct packed {
    pixel_t                    main_px;
    pixel_t                    minor_px;
    pixel_t                    tail_px;
    logic [CLR_COLOR_BITS-1:0] color;
    logic                      done;
  } result_t;

endpackage

// File: design/clr_pixel_clip.sv
// Framebuffer bounds test for one pixel, zeroing clipped coordinates.
`timescale 1ns / 1ps

module clr_pixel_clip import clr_pkg::*; #(
  parameter int COORD_BITS = CLR_COORD_BITS
) (
  input  logic signed [COORD_BITS:0]  pix_x,
  input  logic signed [COORD_BITS:0]  pix_y,
  input  logic                        pix_en,
  input  logic [CLR_FB_BITS-1:0]      fb_width,
  input  logic [CLR_FB_BITS-1:0]      fb_height,
  output pixel_t                      pix
);

  localparam int CMP_BITS = (COORD_BITS + 1 > CLR_FB_BITS) ? COORD_BITS + 1 : CLR_FB_BITS;

  logic [CMP_BITS-1:0] x_u;
  logic [CMP_BITS-1:0] y_u;
  logic [CMP_BITS-1:0] w_u;
  logic [CMP_BITS-1:0] h_u;
  logic                in_bounds;

  // Compare at a common width; a negative coordinate is never inside.
  assign x_u = CMP_BITS'($unsigned(pix_x));
  assign y_u = CMP_BITS'($unsigned(pix_y));
  assign w_u = CMP_BITS'(fb_width);
  assign h_u = CMP_BITS'(fb_height);

  assign in_bounds = !pix_x[COORD_BITS] && !pix_y[COORD_BITS] && (x_u < w_u) && (y_u < h_u);

  // A pixel that is not produced or is clipped reads as all zero.
  assign pix.valid = pix_en && in_bounds;
  assign pix.x     = pix.valid ? x_u[CLR_PIX_BITS-1:0] : '0;
  assign pix.y     = pix.valid ? y_u[CLR_PIX_BITS-1:0] : '0;

endmodule

// File: design/clr_core.sv
// Line state registers and the combinational start and step logic.
`timescale 1ns / 1ps

module clr_core import clr_pkg::*; #(
  parameter int COORD_BITS = CLR_COORD_BITS
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         fire,
  input  logic                         req_type,
  input  logic signed [COORD_BITS-1:0] start_x,
  input  logic signed [COORD_BITS-1:0] start_y,
  input  logic signed [COORD_BITS-1:0] end_x,
  input  logic signed [COORD_BITS-1:0] end_y,
  input  logic [CLR_COLOR_BITS-1:0]    line_color,
  input  logic [CLR_FB_BITS-1:0]       fb_width,
  input  logic [CLR_FB_BITS-1:0]       fb_height,
  output result_t                      res
);

  localparam int W = COORD_BITS;

  // Line state.
  logic                      active_r,  active_nxt;
  kind_t                     kind_r,    kind_nxt;
  logic [W-1:0]              walk_x_r,  walk_x_nxt;
  logic [W-1:0]              walk_y_r,  walk_y_nxt;
  logic [W-1:0]              stop_x_r,  stop_x_nxt;
  logic [W-1:0]              stop_y_r,  stop_y_nxt;
  logic [W-1:0]              major_r,   major_nxt;
  logic [W-1:0]              minor_r,   minor_nxt;
  logic [W:0]                err_r,     err_nxt;
  logic                      dir_r,     dir_nxt;
  logic [CLR_COLOR_BITS-1:0] color_r,   color_nxt;

  // Start classification.
  logic signed [W:0] x1, y1, x2, y2;
  logic signed [W:0] dif_x, dif_y, adx, ady;
  logic [W-1:0]      dx, dy;
  logic              same_x, same_y, x_major, swap;
  logic [W-1:0]      fx, fy, lx, ly;
  kind_t             start_kind;
  logic              start_dir;

  // Step datapath.
  logic signed [W:0] wx, wy, sx, sy, inc;
  logic signed [W:0] wx_n, wy_n;
  logic signed [W:0] mnr_x, mnr_y;
  logic [W:0]        err_sum, err_step;
  logic              minor_hit;
  kind_t             step_kind;
  logic              step_done;
  logic              minor_en;
  logic              main_en;
  logic              tail_en;
  logic              is_start;

  assign is_start = (req_type_t'(req_type) == REQ_START);

  // Endpoint differences and line classification for a start beat.
  assign x1     = {start_x[W-1], start_x};
  assign y1     = {start_y[W-1], start_y};
  assign x2     = {end_x[W-1], end_x};
  assign y2     = {end_y[W-1], end_y};
  assign dif_x  = x2 - x1;
  assign dif_y  = y2 - y1;
  assign adx    = dif_x[W] ? -dif_x : dif_x;
  assign ady    = dif_y[W] ? -dif_y : dif_y;
  assign dx     = adx[W-1:0];
  assign dy     = ady[W-1:0];
  assign same_x = (start_x == end_x);
  assign same_y = (start_y == end_y);
  assign x_major = (dx >= dy);
  assign swap   = x_major ? (end_x < start_x) : (end_y < start_y);
  assign fx     = swap ? end_x : start_x;
  assign fy     = swap ? end_y : start_y;
  assign lx     = swap ? start_x : end_x;
  assign ly     = swap ? start_y : end_y;

  always_comb begin
    if (same_x && same_y) begin
      start_kind = KIND_POINT;
      start_dir  = 1'b0;
    end else if (same_x) begin
      start_kind = KIND_VERT;
      start_dir  = (end_y < start_y);
    end else if (same_y) begin
      start_kind = KIND_HORIZ;
      start_dir  = (end_x < start_x);
    end else if (x_major) begin
      start_kind = KIND_XMAJOR;
      start_dir  = ($signed(ly) < $signed(fy));
    end else begin
      start_kind = KIND_YMAJOR;
      start_dir  = ($signed(lx) < $signed(fx));
    end
  end

  // Current walk position at one extra bit, so an overshoot is seen as such.
  assign wx  = {walk_x_r[W-1], walk_x_r};
  assign wy  = {walk_y_r[W-1], walk_y_r};
  assign sx  = {stop_x_r[W-1], stop_x_r};
  assign sy  = {stop_y_r[W-1], stop_y_r};
  assign inc = dir_r ? '1 : (W+1)'(1);

  // Error accumulator: add the minor span, take a minor step on overflow.
  assign err_sum   = err_r + {1'b0, minor_r};
  assign minor_hit = (err_sum >= {1'b0, major_r});

  // One loop iteration of the walk; the extra pixel sits before the major step.
  always_comb begin
    wx_n      = wx;
    wy_n      = wy;
    mnr_x     = wx;
    mnr_y     = wy;
    err_step  = err_r;
    step_kind = kind_r;
    step_done = 1'b0;
    minor_en  = 1'b0;
    unique case (kind_r)
      KIND_VERT: begin
        wy_n      = wy + inc;
        step_done = (wy_n[W-1:0] == stop_y_r);
      end
      KIND_HORIZ: begin
        wx_n      = wx + inc;
        step_done = (wx_n[W-1:0] == stop_x_r);
      end
      KIND_XMAJOR: begin
        err_step = minor_hit ? err_sum - {1'b0, major_r} : err_sum;
        minor_en = minor_hit;
        if (minor_hit) begin
          wy_n = wy + inc;
        end
        mnr_x     = wx_n;
        mnr_y     = wy_n;
        step_done = (walk_x_r == stop_x_r);
        if (!step_done) begin
          wx_n = wx + (W+1)'(1);
        end
      end
      KIND_YMAJOR: begin
        err_step = minor_hit ? err_sum - {1'b0, major_r} : err_sum;
        minor_en = minor_hit;
        if (minor_hit) begin
          wx_n = wx + inc;
        end
        mnr_x     = wx_n;
        mnr_y     = wy_n;
        step_done = (walk_y_r == stop_y_r);
        if (!step_done) begin
          wy_n = wy + (W+1)'(1);
        end
      end
      default: begin
        step_done = 1'b1;
        step_kind = KIND_POINT;
      end
    endcase
  end

  // Which pixels this beat produces.
  assign main_en = !is_start && active_r;
  assign tail_en = main_en && step_done && (step_kind != KIND_POINT);

  // Next line state.
  always_comb begin
    active_nxt = active_r;
    kind_nxt   = kind_r;
    walk_x_nxt = walk_x_r;
    walk_y_nxt = walk_y_r;
    stop_x_nxt = stop_x_r;
    stop_y_nxt = stop_y_r;
    major_nxt  = major_r;
    minor_nxt  = minor_r;
    err_nxt    = err_r;
    dir_nxt    = dir_r;
    color_nxt  = color_r;
    if (is_start) begin
      active_nxt = 1'b1;
      kind_nxt   = start_kind;
      walk_x_nxt = (start_kind == KIND_XMAJOR || start_kind == KIND_YMAJOR) ? fx : start_x;
      walk_y_nxt = (start_kind == KIND_XMAJOR || start_kind == KIND_YMAJOR) ? fy : start_y;
      stop_x_nxt = (start_kind == KIND_XMAJOR || start_kind == KIND_YMAJOR) ? lx : end_x;
      stop_y_nxt = (start_kind == KIND_XMAJOR || start_kind == KIND_YMAJOR) ? ly : end_y;
      err_nxt    = '0;
      dir_nxt    = start_dir;
      color_nxt  = line_color;
      if (start_kind == KIND_XMAJOR) begin
        major_nxt = dx;
        minor_nxt = dy;
      end else if (start_kind == KIND_YMAJOR) begin
        major_nxt = dy;
        minor_nxt = dx;
      end
    end else if (active_r) begin
      active_nxt = !step_done;
      kind_nxt   = step_kind;
      walk_x_nxt = wx_n[W-1:0];
      walk_y_nxt = wy_n[W-1:0];
      err_nxt    = err_step;
    end
  end

  // Control state is reset; the datapath is loaded by every start beat.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      kind_r   <= KIND_POINT;
      err_r    <= '0;
      dir_r    <= 1'b0;
    end else if (fire) begin
      active_r <= active_nxt;
      kind_r   <= kind_nxt;
      err_r    <= err_nxt;
      dir_r    <= dir_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      walk_x_r <= walk_x_nxt;
      walk_y_r <= walk_y_nxt;
      stop_x_r <= stop_x_nxt;
      stop_y_r <= stop_y_nxt;
      major_r  <= major_nxt;
      minor_r  <= minor_nxt;
      color_r  <= color_nxt;
    end
  end

  // Bounds tests for the three pixels of a step.
  clr_pixel_clip #(.COORD_BITS(COORD_BITS)) u_clip_main (
    .pix_x     (wx),
    .pix_y     (wy),
    .pix_en    (main_en),
    .fb_width  (fb_width),
    .fb_height (fb_height),
    .pix       (res.main_px)
  );

  clr_pixel_clip #(.COORD_BITS(COORD_BITS)) u_clip_minor (
    .pix_x     (mnr_x),
    .pix_y     (mnr_y),
    .pix_en    (main_en && minor_en),
    .fb_width  (fb_width),
    .fb_height (fb_height),
    .pix       (res.minor_px)
  );

  clr_pixel_clip #(.COORD_BITS(COORD_BITS)) u_clip_tail (
    .pix_x     (sx),
    .pix_y     (sy),
    .pix_en    (tail_en),
    .fb_width  (fb_width),
    .fb_height (fb_height),
    .pix       (res.tail_px)
  );

  // Color and completion flag of the result.
  always_comb begin
    if (is_start) begin
      res.color = line_color;
      res.done  = 1'b0;
    end else if (active_r) begin
      res.color = color_r;
      res.done  = step_done;
    end else begin
      res.color = '0;
      res.done  = 1'b1;
    end
  end

endmodule

// File: design/clipped_line_rasterizer.sv
// Top level of the clipped line rasterizer: handshake, configuration and result register.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// A start beat loads a line and a color; each following step beat walks one
// iteration of the line and returns its main pixel, an extra pixel when the
// minor axis steps, and the endpoint pixel on the final iteration, each
// clipped against fb_width and fb_height. One beat is accepted every cycle
// unless the result register is full and is not being taken in the same
// cycle, so a full register that is being taken does not block the next
// input beat. A beat's result is in the output register in the following
// cycle. There is no clearing pass after reset.
module clipped_line_rasterizer import clr_pkg::*; #(
  parameter int COORD_BITS = CLR_COORD_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // Configuration write port.
  input  logic                          cfg_we,
  input  logic [CLR_CFG_ADDR_BITS-1:0]  cfg_addr,
  input  logic [CLR_FB_BITS-1:0]        cfg_wdata,
  // Input channel.
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_req_type,
  input  logic signed [COORD_BITS-1:0]  in_start_x,
  input  logic signed [COORD_BITS-1:0]  in_start_y,
  input  logic signed [COORD_BITS-1:0]  in_end_x,
  input  logic signed [COORD_BITS-1:0]  in_end_y,
  input  logic [CLR_COLOR_BITS-1:0]     in_line_color,
  // Result channel.
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [CLR_PIX_BITS-1:0]       out_main_x,
  output logic [CLR_PIX_BITS-1:0]       out_main_y,
  output logic                          out_main_valid,
  output logic [CLR_PIX_BITS-1:0]       out_minor_x,
  output logic [CLR_PIX_BITS-1:0]       out_minor_y,
  output logic                          out_minor_valid,
  output logic [CLR_PIX_BITS-1:0]       out_tail_x,
  output logic [CLR_PIX_BITS-1:0]       out_tail_y,
  output logic                          out_tail_valid,
  output logic [CLR_COLOR_BITS-1:0]     out_pixel_color,
  output logic                          out_line_done
);

  logic [CLR_FB_BITS-1:0] fb_width_r;
  logic [CLR_FB_BITS-1:0] fb_height_r;
  logic                   out_valid_r;
  result_t                res_r;
  result_t                res;
  logic                   fire;
  logic                   start_fire;
  logic                   res_blank;
  logic                   main_zero;

  // Accept a beat whenever the result register is empty or being emptied.
  assign in_ready = !out_valid_r || out_ready;
  assign fire     = in_valid && in_ready;

  // Framebuffer size registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fb_width_r  <= CLR_FB_WIDTH_RST;
      fb_height_r <= CLR_FB_HEIGHT_RST;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_addr))
        CFG_FB_WIDTH:  fb_width_r  <= cfg_wdata;
        CFG_FB_HEIGHT: fb_height_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Line state and step logic.
  clr_core #(.COORD_BITS(COORD_BITS)) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .fire       (fire),
    .req_type   (in_req_type),
    .start_x    (in_start_x),
    .start_y    (in_start_y),
    .end_x      (in_end_x),
    .end_y      (in_end_y),
    .line_color (in_line_color),
    .fb_width   (fb_width_r),
    .fb_height  (fb_height_r),
    .res        (res)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_r <= res;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_main_x      = res_r.main_px.x;
  assign out_main_y      = res_r.main_px.y;
  assign out_main_valid  = res_r.main_px.valid;
  assign out_minor_x     = res_r.minor_px.x;
  assign out_minor_y     = res_r.minor_px.y;
  assign out_minor_valid = res_r.minor_px.valid;
  assign out_tail_x      = res_r.tail_px.x;
  assign out_tail_y      = res_r.tail_px.y;
  assign out_tail_valid  = res_r.tail_px.valid;
  assign out_pixel_color = res_r.color;
  assign out_line_done   = res_r.done;

  // Terms used by the checks below.
  assign start_fire = fire && (in_req_type == REQ_START);
  assign res_blank  = !res_r.done && !res_r.main_px.valid && !res_r.minor_px.valid
                      && !res_r.tail_px.valid;
  assign main_zero  = (res_r.main_px.x == '0) && (res_r.main_px.y == '0);

  // Every accepted beat leaves a result in the register.
  `CLR_ASSERT_NEXT(a_fire_loads, fire, out_valid_r)
  // A start beat gives no pixels and does not finish the line.
  `CLR_ASSERT_NEXT(a_start_result, start_fire, res_blank)
  // The endpoint pixel only comes with the final step.
  `CLR_ASSERT(a_tail_done, !out_valid_r || !res_r.tail_px.valid || res_r.done)
  // A clipped main pixel reads as zero.
  `CLR_ASSERT(a_main_zero, res_r.main_px.valid || !out_valid_r || main_zero)

endmodule

// File: tb/clipped_line_rasterizer_test.sv
// Self-checking testbench for the clipped line rasterizer: directed lines, random walks, clipping.
`timescale 1ns / 1ps

module clipped_line_rasterizer_test import clr_pkg::*; ();

  logic                         clk;
  logic                         rst_n;
  logic                         cfg_we;
  logic [CLR_CFG_ADDR_BITS-1:0] cfg_addr;
  logic [CLR_FB_BITS-1:0]       cfg_wdata;
  logic                         in_valid;
  logic                         in_ready;
  logic                         in_req_type;
  logic [11:0]                  in_start_x;
  logic [11:0]                  in_start_y;
  logic [11:0]                  in_end_x;
  logic [11:0]                  in_end_y;
  logic [31:0]                  in_line_color;
  logic                         out_valid;
  logic                         out_ready;
  logic [CLR_PIX_BITS-1:0]      out_main_x;
  logic [CLR_PIX_BITS-1:0]      out_main_y;
  logic                         out_main_valid;
  logic [CLR_PIX_BITS-1:0]      out_minor_x;
  logic [CLR_PIX_BITS-1:0]      out_minor_y;
  logic                         out_minor_valid;
  logic [CLR_PIX_BITS-1:0]      out_tail_x;
  logic [CLR_PIX_BITS-1:0]      out_tail_y;
  logic                         out_tail_valid;
  logic [CLR_COLOR_BITS-1:0]    out_pixel_color;
  logic                         out_line_done;

  clipped_line_rasterizer uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_addr        (cfg_addr),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_req_type     (in_req_type),
    .in_start_x      (in_start_x),
    .in_start_y      (in_start_y),
    .in_end_x        (in_end_x),
    .in_end_y        (in_end_y),
    .in_line_color   (in_line_color),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_main_x      (out_main_x),
    .out_main_y      (out_main_y),
    .out_main_valid  (out_main_valid),
    .out_minor_x     (out_minor_x),
    .out_minor_y     (out_minor_y),
    .out_minor_valid (out_minor_valid),
    .out_tail_x      (out_tail_x),
    .out_tail_y      (out_tail_y),
    .out_tail_valid  (out_tail_valid),
    .out_pixel_color (out_pixel_color),
    .out_line_done   (out_line_done)
  );

  // Line tracker state, mirrors what the block holds between beats.
  logic [11:0] fb_w;
  logic [11:0] fb_h;
  bit          trk_active;
  kind_t       trk_kind;
  logic [11:0] trk_walk_x;
  logic [11:0] trk_walk_y;
  logic [11:0] trk_stop_x;
  logic [11:0] trk_stop_y;
  logic [11:0] trk_major;
  logic [11:0] trk_minor;
  logic [12:0] trk_err;
  bit          trk_dir;
  logic [31:0] trk_color;

  // Pending pixel results, oldest first.
  result_t pixel_q[$];

  int  beats_sent;
  int  lines_started;
  int  results_checked;
  int  mismatch_count;
  int  cfg_writes;
  bit  burst_mode;

  // Free-running clock.
  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic int sext12(logic [11:0] v);
    return int'($signed(v));
  endfunction

  function automatic int clamp_coord(int v);
    if (v < -2048) return -2048;
    if (v > 2047) return 2047;
    return v;
  endfunction

  function automatic logic [11:0] rand_coord();
    return 12'($urandom_range(0, 4095));
  endfunction

  // Clip one pixel against the current framebuffer size at full precision.
  function automatic pixel_t clip_pixel(int x, int y);
    pixel_t p;
    p = '0;
    if (x >= 0 && y >= 0 && x < int'(fb_w) && y < int'(fb_h)) begin
      p.x = x[10:0];
      p.y = y[10:0];
      p.valid = 1'b1;
    end
    return p;
  endfunction

  // Work out the result of one accepted beat and advance the tracker.
  task automatic predict_pixels(input logic req, input logic [11:0] sx, input logic [11:0] sy,
                                input logic [11:0] ex, input logic [11:0] ey,
                                input logic [31:0] color, output result_t r);
    int x1, y1, x2, y2, dx, dy, t, wx, wy, inc;
    bit fin, swap;
    r = '0;
    if (req == REQ_START) begin
      x1 = sext12(sx);
      y1 = sext12(sy);
      x2 = sext12(ex);
      y2 = sext12(ey);
      dx = (x1 < x2) ? x2 - x1 : x1 - x2;
      dy = (y1 < y2) ? y2 - y1 : y1 - y2;
      trk_color = color;
      trk_err = '0;
      trk_dir = 1'b0;
      if (x1 == x2 && y1 == y2) begin
        trk_kind = KIND_POINT;
      end else if (x1 == x2) begin
        trk_kind = KIND_VERT;
        trk_dir = (y1 <= y2) ? 1'b0 : 1'b1;
      end else if (y1 == y2) begin
        trk_kind = KIND_HORIZ;
        trk_dir = (x1 <= x2) ? 1'b0 : 1'b1;
      end else begin
        if (dx >= dy) begin
          trk_kind = KIND_XMAJOR;
          swap = (x2 < x1);
        end else begin
          trk_kind = KIND_YMAJOR;
          swap = (y2 < y1);
        end
        // Sloped lines always walk the major axis upward.
        if (swap) begin
          t = x1; x1 = x2; x2 = t;
          t = y1; y1 = y2; y2 = t;
        end
        if (trk_kind == KIND_XMAJOR) begin
          trk_major = dx[11:0];
          trk_minor = dy[11:0];
          trk_dir = (y2 >= y1) ? 1'b0 : 1'b1;
        end else begin
          trk_major = dy[11:0];
          trk_minor = dx[11:0];
          trk_dir = (x2 >= x1) ? 1'b0 : 1'b1;
        end
      end
      trk_walk_x = x1[11:0];
      trk_walk_y = y1[11:0];
      trk_stop_x = x2[11:0];
      trk_stop_y = y2[11:0];
      trk_active = 1'b1;
      r.color = color;
    end else if (!trk_active) begin
      // A step with no line loaded only reports done.
      r.done = 1'b1;
    end else begin
      wx = sext12(trk_walk_x);
      wy = sext12(trk_walk_y);
      inc = trk_dir ? -1 : 1;
      fin = 1'b0;
      r.main_px = clip_pixel(wx, wy);
      case (trk_kind) inside
        KIND_VERT: begin
          wy = wy + inc;
          fin = (wy[11:0] == trk_stop_y);
        end
        KIND_HORIZ: begin
          wx = wx + inc;
          fin = (wx[11:0] == trk_stop_x);
        end
        KIND_XMAJOR, KIND_YMAJOR: begin
          trk_err = trk_err + {1'b0, trk_minor};
          // The minor pixel is clipped before any wrap, so an overshoot stays out.
          if (trk_err >= {1'b0, trk_major}) begin
            trk_err = trk_err - {1'b0, trk_major};
            if (trk_kind == KIND_XMAJOR) wy = wy + inc;
            else wx = wx + inc;
            r.minor_px = clip_pixel(wx, wy);
          end
          if (trk_kind == KIND_XMAJOR) begin
            if (wx[11:0] == trk_stop_x) fin = 1'b1;
            else wx = wx + 1;
          end else begin
            if (wy[11:0] == trk_stop_y) fin = 1'b1;
            else wy = wy + 1;
          end
        end
        default: begin
          fin = 1'b1;
          trk_kind = KIND_POINT;
        end
      endcase
      if (fin && trk_kind != KIND_POINT) begin
        r.tail_px = clip_pixel(sext12(trk_stop_x), sext12(trk_stop_y));
      end
      trk_walk_x = wx[11:0];
      trk_walk_y = wy[11:0];
      r.color = trk_color;
      r.done = fin;
      if (fin) trk_active = 1'b0;
    end
  endtask

  // Idle cycles before a beat: mostly none or a few, now and then a long one.
  function automatic int pick_gap();
    int r;
    if (burst_mode) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Present one beat, hold it until accepted, and queue its expected result.
  task automatic send_beat(input logic req, input logic [11:0] sx, input logic [11:0] sy,
                           input logic [11:0] ex, input logic [11:0] ey,
                           input logic [31:0] color);
    int gap;
    result_t want;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_req_type   <= req;
    in_start_x    <= sx;
    in_start_y    <= sy;
    in_end_x      <= ex;
    in_end_y      <= ey;
    in_line_color <= color;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_pixels(req, sx, sy, ex, ey, color, want);
    pixel_q.push_back(want);
    beats_sent++;
  endtask

  // Stop sending and wait until every expected result has been taken.
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pixel_q.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input int unsigned value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= value[11:0];
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_FB_WIDTH) fb_w = value[11:0];
    else fb_h = value[11:0];
    cfg_writes++;
  endtask

  // Load a line and step it until it finishes or the step budget runs out.
  task automatic walk_line(input int x1, input int y1, input int x2, input int y2,
                           input logic [31:0] color, input int max_steps);
    int n;
    n = 0;
    send_beat(REQ_START, x1[11:0], y1[11:0], x2[11:0], y2[11:0], color);
    lines_started++;
    while (trk_active && n < max_steps) begin
      send_beat(REQ_STEP, rand_coord(), rand_coord(), rand_coord(), rand_coord(), $urandom);
      n++;
    end
  endtask

  task automatic idle_step();
    send_beat(REQ_STEP, rand_coord(), rand_coord(), rand_coord(), rand_coord(), $urandom);
  endtask

  // Start coordinate: mostly near the framebuffer, sometimes at the range ends or anywhere.
  function automatic int pick_coord(int lim);
    case ($urandom_range(0, 9))
      0: return sext12(rand_coord());
      1: return $urandom_range(0, 1) ? 2047 - int'($urandom_range(0, 7))
                                     : -2048 + int'($urandom_range(0, 7));
      default: return clamp_coord(int'($urandom_range(0, lim + 8)) - 8);
    endcase
  endfunction

  task automatic test_idle_and_point();
    idle_step();
    walk_line(639, 479, 639, 479, 32'hFFFF_FFFF, 1 << 20);
    idle_step();
  endtask

  task automatic test_axis_lines();
    // Vertical line walked downward, horizontal line entering from negative x.
    walk_line(3, 2, 3, 0, 32'h1234_5678, 1 << 20);
    walk_line(-1, 5, 1, 5, 32'h8765_4321, 1 << 20);
  endtask

  task automatic test_sloped_lines();
    // X-major with swapped endpoints, y-major with the minor axis going negative.
    walk_line(5, 1, 2, 0, 32'hA5A5_5A5A, 1 << 20);
    walk_line(0, 0, -1, 2, 32'h5A5A_A5A5, 1 << 20);
    // Equal spans: the last minor pixel lands just past the framebuffer corner.
    walk_line(636, 476, 639, 479, 32'h0F0F_F0F0, 1 << 20);
  endtask

  task automatic test_restart();
    // A start while a line is active drops the old one.
    walk_line(-2048, 2047, 2047, -2048, 32'hFFFF_FFFF, 1);
    walk_line(-2048, -2048, -2048, -2048, 32'h0000_0000, 1);
  endtask

  task automatic test_random_lines();
    int unsigned widths[8];
    int unsigned heights[8];
    int phase, phase_beats, r, x1, y1, x2, y2, span, len;
    widths  = '{640, 1, 2047, 2048, 64, 16, 8, 0};
    heights = '{480, 1, 2047, 300, 2048, 12, 2047, 0};
    widths[6]  = $urandom_range(1, 2048);
    heights[6] = $urandom_range(1, 2048);
    for (phase = 0; phase < 8; phase++) begin
      // Registers change only with nothing in flight.
      drain_results();
      write_reg(CFG_FB_WIDTH, widths[phase]);
      write_reg(CFG_FB_HEIGHT, heights[phase]);
      phase_beats = beats_sent;
      while (beats_sent - phase_beats < 142) begin
        burst_mode = ($urandom_range(0, 3) == 0);
        r = $urandom_range(0, 99);
        x1 = pick_coord(int'(fb_w));
        y1 = pick_coord(int'(fb_h));
        if (r < 72) begin
          span = ($urandom_range(0, 4) == 0) ? 40 : 8;
          x2 = clamp_coord(x1 + int'($urandom_range(0, 2 * span)) - span);
          y2 = clamp_coord(y1 + int'($urandom_range(0, 2 * span)) - span);
          walk_line(x1, y1, x2, y2, $urandom, 1 << 20);
          if ($urandom_range(0, 4) == 0) idle_step();
        end else if (r < 84) begin
          // Diagonal unless an end is clamped at the coordinate range, so mostly the minor axis steps every iteration.
          len = $urandom_range(1, 10);
          x2 = clamp_coord(x1 + ($urandom_range(0, 1) ? len : -len));
          y2 = clamp_coord(y1 + ($urandom_range(0, 1) ? len : -len));
          walk_line(x1, y1, x2, y2, $urandom, 1 << 20);
        end else if (r < 93) begin
          // Arbitrary endpoints, abandoned after a few steps.
          walk_line(sext12(rand_coord()), sext12(rand_coord()), sext12(rand_coord()),
                    sext12(rand_coord()), $urandom, $urandom_range(0, 6));
        end else begin
          idle_step();
        end
      end
    end
    burst_mode = 1'b0;
  endtask

  // Receiver: bursts of ready, long stalls, and stretches of random ready.
  initial begin : drive_out_ready
    int r, n, i;
    out_ready = 1'b0;
    forever begin
      r = $urandom_range(0, 99);
      n = $urandom_range(1, 8);
      if (r < 20) n = $urandom_range(5, 40);
      else if (r < 30) n = $urandom_range(10, 30);
      for (i = 0; i < n; i++) begin
        @(negedge clk);
        if (r < 20) out_ready <= 1'b1;
        else if (r < 30) out_ready <= 1'b0;
        else out_ready <= ($urandom_range(0, 9) < 7);
      end
    end
  end

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      mismatch_count++;
      if (mismatch_count <= 10) begin
        $display("mismatch on %s of result %0d: expected %0h, got %0h",
                 name, results_checked, want, got);
      end
    end
  endtask

  // Compare every result beat with the oldest expected one.
  always @(posedge clk) begin : check_results
    result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pixel_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("result beat arrived with nothing expected");
      end else begin
        want = pixel_q.pop_front();
        compare_field("main_x", 32'(want.main_px.x), 32'(out_main_x));
        compare_field("main_y", 32'(want.main_px.y), 32'(out_main_y));
        compare_field("main_valid", 32'(want.main_px.valid), 32'(out_main_valid));
        compare_field("minor_x", 32'(want.minor_px.x), 32'(out_minor_x));
        compare_field("minor_y", 32'(want.minor_px.y), 32'(out_minor_y));
        compare_field("minor_valid", 32'(want.minor_px.valid), 32'(out_minor_valid));
        compare_field("tail_x", 32'(want.tail_px.x), 32'(out_tail_x));
        compare_field("tail_y", 32'(want.tail_px.y), 32'(out_tail_y));
        compare_field("tail_valid", 32'(want.tail_px.valid), 32'(out_tail_valid));
        compare_field("pixel_color", want.color, out_pixel_color);
        compare_field("line_done", 32'(want.done), 32'(out_line_done));
        results_checked++;
      end
    end
  end

  // Watchdog against a hung handshake.
  initial begin
    #5_000_000;
    $display("clipped_line_rasterizer_test: FAIL");
    $finish;
  end

  initial begin
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_addr      = '0;
    cfg_wdata     = '0;
    in_valid      = 1'b0;
    in_req_type   = 1'b0;
    in_start_x    = '0;
    in_start_y    = '0;
    in_end_x      = '0;
    in_end_y      = '0;
    in_line_color = '0;
    fb_w          = CLR_FB_WIDTH_RST;
    fb_h          = CLR_FB_HEIGHT_RST;
    trk_active    = 1'b0;
    trk_kind      = KIND_POINT;
    trk_walk_x    = '0;
    trk_walk_y    = '0;
    trk_stop_x    = '0;
    trk_stop_y    = '0;
    trk_major     = '0;
    trk_minor     = '0;
    trk_err       = '0;
    trk_dir       = 1'b0;
    trk_color     = '0;
    burst_mode    = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_idle_and_point();
    test_axis_lines();
    test_sloped_lines();
    test_restart();
    test_random_lines();

    drain_results();
    $display("Sent %0d beats over %0d lines; %0d results checked, %0d register writes.",
             beats_sent, lines_started, results_checked, cfg_writes);
    $display("Framebuffer sizes ranged from zero and 1x1 up to 2048 on a side.");
    if (mismatch_count == 0 && pixel_q.size() == 0) begin
      $display("clipped_line_rasterizer_test: PASS");
    end else begin
      $display("clipped_line_rasterizer_test: FAIL");
    end
    $finish;
  end

endmodule
